[rtl/tet_pkg.sv]
package tet_pkg;
  localparam int TABLE_SLOTS = 64;
  localparam int TIME_BITS = 48;
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = SLOT_W + 1;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_TICK = 2'd2,
    MODE_COMPACT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FIRED = 2'd1,
    ST_FULL = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SL_FREE = 2'd0,
    SL_TOMB = 2'd1,
    SL_BUSY = 2'd2
  } slot_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  timer_id;
    logic [47:0] deadline;
    logic [47:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  fired_id;
    logic [47:0] fire_time;
    logic        last;
  } out_item_t;

  typedef struct packed {
    mode_t                mode;
    logic [7:0]           timer_id;
    logic [TIME_BITS-1:0] tval;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_CLEAR,
    B_SEL,
    B_SELW,
    B_EMIT
  } bstate_t;
endpackage

[rtl/tet_front.sv]
module tet_front
  import tet_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     q_valid,
  input  logic     q_take,
  output cmd_t     q_cmd
);
  cmd_t q0, q1;
  logic [1:0] cnt;
  cmd_t cin;
  logic push, pop;

  always_comb begin
    cin.mode = mode_t'(in_item.mode);
    cin.timer_id = in_item.timer_id;
    cin.tval = (in_item.mode == MODE_TICK) ? in_item.now_time[TIME_BITS-1:0]
                                           : in_item.deadline[TIME_BITS-1:0];
  end

  assign in_stall = (cnt == 2'd2);
  assign push = in_valid && !in_stall;
  assign pop = q_take && (cnt != 2'd0);
  assign q_valid = (cnt != 2'd0);
  assign q_cmd = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (pop) begin
      q0 <= (push && cnt == 2'd1) ? cin : q1;
    end else if (push && cnt == 2'd0) begin
      q0 <= cin;
    end
    if (push && ((cnt == 2'd1 && !pop) || (cnt == 2'd2 && pop))) begin
      q1 <= cin;
    end
  end
endmodule

[rtl/tet_back.sv]
module tet_back
  import tet_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_take,
  input  cmd_t      q_cmd,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);
  logic [1:0]           st_mem [TABLE_SLOTS];
  logic [7:0]           id_mem [TABLE_SLOTS];
  logic [TIME_BITS-1:0] dl_mem [TABLE_SLOTS];
  logic [SLOT_W-1:0]    due_list [TABLE_SLOTS];
  logic [CNT_W-1:0]     due_count;

  bstate_t state, state_next;
  cmd_t cmd;
  logic [CNT_W-1:0] i, j, n, k;
  logic [SLOT_W-1:0] ix, jx;
  logic [SLOT_W-1:0] ra, ra_q, dsl;
  logic [CNT_W-1:0] dk_q;
  logic rd_ok, dl_ok, emit_go;
  logic [1:0] rs;
  logic [7:0] rid;
  logic [TIME_BITS-1:0] rdl;
  logic [1:0] clr_cnt;
  logic bfound;
  logic [SLOT_W-1:0] best;
  logic [TIME_BITS-1:0] bdl, prev_dl;
  logic [SLOT_W-1:0] prev_slot;
  logic have_prev;
  logic better, after_prev;

  assign ix = i[SLOT_W-1:0];
  assign jx = j[SLOT_W-1:0];
  assign ra = (state == B_EMIT) ? dsl : ix;
  assign rd_ok = (ra_q == ra);
  assign dl_ok = (dk_q == k);
  assign emit_go = (state == B_EMIT) && (due_count != '0) && dl_ok && rd_ok &&
                   (!out_valid || !out_stall);
  assign q_take = (state == B_IDLE) && !out_valid && (clr_cnt == 2'd2);

  // registered table reads; data is for ra_q
  always_ff @(posedge clk) begin
    rs <= st_mem[ra];
    rid <= id_mem[ra];
    rdl <= dl_mem[ra];
    ra_q <= ra;
    dsl <= due_list[k[SLOT_W-1:0]];
    dk_q <= k;
  end

  always_comb begin
    after_prev = !have_prev || (rdl > prev_dl) ||
                 (rdl == prev_dl && ix > prev_slot);
    better = !bfound || (rdl < bdl);
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (q_take && q_valid) state_next = B_SCAN;
      default: state_next = state;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
      clr_cnt <= 2'd0;
      i <= '0;
      due_count <= '0;
    end else begin
      if (out_valid && !out_stall && !emit_go) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (clr_cnt != 2'd2) begin
            st_mem[ix] <= SL_FREE;
            i <= i + 1'b1;
            if (i == CNT_W'(TABLE_SLOTS - 1)) begin
              clr_cnt <= 2'd2;
              i <= '0;
            end
          end else if (q_take && q_valid) begin
            cmd <= q_cmd;
            state <= state_next;
            i <= '0;
            j <= '0;
            n <= '0;
          end
        end
        B_SCAN: begin
          case (cmd.mode)
            MODE_ADD: begin
              if (rd_ok) begin
                if (rs != SL_BUSY) begin
                  st_mem[ix] <= SL_BUSY;
                  id_mem[ix] <= cmd.timer_id;
                  dl_mem[ix] <= cmd.tval;
                  out_item <= '{ST_DONE, 8'd0, 48'd0, 1'b1};
                  out_valid <= 1'b1;
                  state <= B_IDLE;
                end else if (i == CNT_W'(TABLE_SLOTS - 1)) begin
                  out_item <= '{ST_FULL, 8'd0, 48'd0, 1'b1};
                  out_valid <= 1'b1;
                  state <= B_IDLE;
                end
                i <= i + 1'b1;
              end
            end
            MODE_REMOVE: begin
              if (rd_ok) begin
                if (rs == SL_FREE || i == CNT_W'(TABLE_SLOTS - 1) ||
                    (rs == SL_BUSY && rid == cmd.timer_id)) begin
                  if (rs == SL_BUSY && rid == cmd.timer_id) st_mem[ix] <= SL_TOMB;
                  out_item <= '{ST_DONE, 8'd0, 48'd0, 1'b1};
                  out_valid <= 1'b1;
                  state <= B_IDLE;
                end
                i <= i + 1'b1;
              end
            end
            MODE_COMPACT: begin
              if (rd_ok) begin
                if (rs == SL_FREE) begin
                  state <= B_CLEAR;
                end else begin
                  if (rs == SL_BUSY) begin
                    st_mem[jx] <= SL_BUSY;
                    id_mem[jx] <= rid;
                    dl_mem[jx] <= rdl;
                    j <= j + 1'b1;
                  end
                  if (i == CNT_W'(TABLE_SLOTS - 1)) state <= B_CLEAR;
                  i <= i + 1'b1;
                end
              end
            end
            default: begin
              i <= '0;
              n <= '0;
              have_prev <= 1'b0;
              bfound <= 1'b0;
              state <= B_SEL;
            end
          endcase
        end
        B_CLEAR: begin
          if (j == CNT_W'(TABLE_SLOTS)) begin
            out_item <= '{ST_DONE, 8'd0, 48'd0, 1'b1};
            out_valid <= 1'b1;
            state <= B_IDLE;
          end else begin
            st_mem[jx] <= SL_FREE;
            j <= j + 1'b1;
          end
        end
        B_SEL: begin
          if (rd_ok) begin
            if (rs == SL_BUSY && rdl <= cmd.tval && after_prev && better) begin
              bfound <= 1'b1;
              best <= ix;
              bdl <= rdl;
            end
            if (i == CNT_W'(TABLE_SLOTS - 1)) begin
              state <= B_SELW;
            end
            i <= i + 1'b1;
          end
        end
        B_SELW: begin
          if (bfound) begin
            due_list[n[SLOT_W-1:0]] <= best;
            n <= n + 1'b1;
            have_prev <= 1'b1;
            prev_dl <= bdl;
            prev_slot <= best;
            bfound <= 1'b0;
            i <= '0;
            state <= (n == CNT_W'(TABLE_SLOTS - 1)) ? B_EMIT : B_SEL;
            if (n == CNT_W'(TABLE_SLOTS - 1)) begin
              due_count <= n + 1'b1;
              k <= '0;
            end
          end else begin
            due_count <= n;
            k <= '0;
            state <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (due_count == '0) begin
            out_item <= '{ST_NONE, 8'd0, 48'd0, 1'b1};
            out_valid <= 1'b1;
            state <= B_IDLE;
          end else if (emit_go) begin
            st_mem[dsl] <= SL_TOMB;
            out_item.status <= ST_FIRED;
            out_item.fired_id <= rid;
            out_item.fire_time <= rdl;
            out_item.last <= (k + 1'b1 == due_count);
            out_valid <= 1'b1;
            k <= k + 1'b1;
            if (k + 1'b1 == due_count) state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

[rtl/timer_expiry_table.sv]
// channel | signals                  | accepted when
// in      | in_valid, in_stall, in   | in_valid && !in_stall
// out     | out_valid, out_stall, out | out_valid && !out_stall
// Table reads are registered, so each slot visit waits for its read data.
// Add, remove and compact visit up to TABLE_SLOTS slots; compact then clears
// the freed tail. A tick runs one selection pass per fired timer plus a final
// empty pass unless every slot fires, then emits the results. After reset a
// clearing pass runs before the first item. A two-entry queue decouples
// acceptance from the table engine; out_stall holds the result.
module timer_expiry_table
  import tet_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out
);
  logic q_valid, q_take;
  cmd_t q_cmd;

  tet_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
  );

  tet_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out)
  );
endmodule
